[src/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg: shared constants for the terminal line editor
// Key codes, result kinds and field widths used by the core and its checker.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LEN_W  = 7;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [KIND_W-1:0] kind_t;

  // Result kinds.
  localparam kind_t KIND_STATUS = 2'd0;
  localparam kind_t KIND_CHAR   = 2'd1;
  localparam kind_t KIND_CANCEL = 2'd2;
  localparam kind_t KIND_EMPTY  = 2'd3;

  // Control keys.
  localparam char_t KEY_NUL   = 8'd0;
  localparam char_t KEY_HOME  = 8'd1;
  localparam char_t KEY_CTLB  = 8'd2;
  localparam char_t KEY_CTLC  = 8'd3;
  localparam char_t KEY_DEL   = 8'd4;
  localparam char_t KEY_END   = 8'd5;
  localparam char_t KEY_RIGHT = 8'd6;
  localparam char_t KEY_BS    = 8'd8;
  localparam char_t KEY_LF    = 8'd10;
  localparam char_t KEY_KILL  = 8'd11;
  localparam char_t KEY_CR    = 8'd13;
  localparam char_t KEY_CTLO  = 8'd15;
  localparam char_t KEY_XPOSE = 8'd20;
  localparam char_t KEY_KHOME = 8'd21;
  localparam char_t KEY_WORD  = 8'd23;
  localparam char_t KEY_ESC   = 8'd27;
  localparam char_t KEY_RUB   = 8'd127;

  // Printable characters used by the escape decoder and word search.
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_O     = 8'h4F;
  localparam char_t CH_BRACK = 8'h5B;
  localparam char_t CH_TILDE = 8'h7E;
  localparam char_t CH_3     = 8'h33;
  localparam char_t CH_H     = 8'h48;
  localparam char_t CH_F     = 8'h46;
  localparam char_t CH_C     = 8'h43;
  localparam char_t CH_D     = 8'h44;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;

endpackage

[src/tle_mem.sv]
// ----------------------------------------------------------------------------
// tle_mem: line store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tle_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  tle_pkg::char_t        wdata,
  input  logic [AW-1:0]         raddr,
  output tle_pkg::char_t        rdata
);
  import tle_pkg::*;

  char_t mem [DEPTH];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/terminal_line_editor_core.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor_core: emacs-style line editor
// Takes key bytes, edits a line held in a single-port-write memory.
// ----------------------------------------------------------------------------
// A key that only moves the cursor or is ignored goes straight to its status
// request. Inserts and deletes walk the line store one entry a cycle, and
// delete-previous-word first scans back, reading and checking one character
// at a time. Enter reads each character of the line from the store before
// its request. The line store has no reset and needs no clearing pass. A new
// key is taken only when the previous one is fully worked off; the output
// register lets it arrive while the last result still waits.
module terminal_line_editor_core #(
  parameter int MAX_LEN = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  tle_pkg::char_t  key,
  output logic            out_valid,
  input  logic            out_stall,
  output tle_pkg::kind_t  kind,
  output tle_pkg::char_t  text_char,
  output tle_pkg::len_t   cursor,
  output tle_pkg::len_t   line_length,
  output logic            full_res,
  output logic            last
);
  import tle_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam len_t LMAX = LEN_W'(MAX_LEN);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DOWN = 4'd1;
  localparam logic [3:0] S_UP   = 4'd2;
  localparam logic [3:0] S_INS  = 4'd3;
  localparam logic [3:0] S_T0   = 4'd4;
  localparam logic [3:0] S_T1   = 4'd5;
  localparam logic [3:0] S_T2   = 4'd6;
  localparam logic [3:0] S_T3   = 4'd7;
  localparam logic [3:0] S_WREQ = 4'd8;
  localparam logic [3:0] S_WCHK = 4'd9;
  localparam logic [3:0] S_EREQ = 4'd10;
  localparam logic [3:0] S_EDAT = 4'd11;
  localparam logic [3:0] S_RESP = 4'd12;

  // Escape sequence phases.
  localparam logic [1:0] ESC_IDLE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;
  localparam logic [1:0] ESC_DIGIT  = 2'd3;

  // Control state.
  logic [3:0] state, state_next;
  len_t       cur, cur_next, len, len_next;
  logic [1:0] ph, ph_next;
  logic       pv, pv_next;
  logic       ovalid, ovalid_next;

  // Working registers.
  char_t          held, held_next, kreg, kreg_next, ta, ta_next;
  kind_t          kind_r, kind_r_next;
  logic           full_r, full_r_next, wph, wph_next;
  len_t           src, src_next, gap, gap_next, dcur, dcur_next, cnt, cnt_next;
  len_t           tp, tp_next, wp, wp_next, ei, ei_next, en, en_next;
  logic [AW-1:0]  pdst, pdst_next;

  // Output payload.
  kind_t okind, okind_next;
  char_t ochar, ochar_next;
  len_t  ocur, ocur_next, olen, olen_next;
  logic  ofull, ofull_next, olast, olast_next;

  // Memory port.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  char_t         wdata, rdata;
  len_t          tmp;
  logic          accept, slot_free;

  tle_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !ovalid || !out_stall;

  // Next-state and datapath control.
  always_comb begin
    state_next  = state;
    cur_next    = cur;
    len_next    = len;
    ph_next     = ph;
    pv_next     = pv;
    held_next   = held;
    kreg_next   = kreg;
    ta_next     = ta;
    kind_r_next = kind_r;
    full_r_next = full_r;
    wph_next    = wph;
    src_next    = src;
    gap_next    = gap;
    dcur_next   = dcur;
    cnt_next    = cnt;
    tp_next     = tp;
    wp_next     = wp;
    ei_next     = ei;
    en_next     = en;
    pdst_next   = pdst;
    ovalid_next = ovalid && out_stall;
    okind_next  = okind;
    ochar_next  = ochar;
    ocur_next   = ocur;
    olen_next   = olen;
    ofull_next  = ofull;
    olast_next  = olast;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rdata;
    raddr       = '0;
    tmp         = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          kreg_next   = key;
          kind_r_next = KIND_STATUS;
          full_r_next = 1'b0;
          state_next  = S_RESP;
          if (key == KEY_NUL || (ph == ESC_IDLE && key == KEY_CTLC)) begin
            // Cancel the line.
            cur_next    = '0;
            len_next    = '0;
            ph_next     = ESC_IDLE;
            held_next   = '0;
            kind_r_next = KIND_CANCEL;
          end else if (ph == ESC_FIRST) begin
            held_next = key;
            ph_next   = ESC_SECOND;
          end else if (ph == ESC_SECOND) begin
            // Second byte after ESC.
            ph_next = ESC_IDLE;
            if (held == CH_O) begin
              if (key == CH_H) cur_next = '0;
              else if (key == CH_F) cur_next = len;
            end else if (held == CH_BRACK) begin
              if (key >= CH_0 && key <= CH_9) begin
                held_next = key;
                ph_next   = ESC_DIGIT;
              end else if (key == CH_C) begin
                if (cur < len) cur_next = cur + 1'b1;
              end else if (key == CH_D) begin
                if (cur != '0) cur_next = cur - 1'b1;
              end else if (key == CH_H) begin
                cur_next = '0;
              end else if (key == CH_F) begin
                cur_next = len;
              end
            end
          end else if (ph == ESC_DIGIT) begin
            // Final byte of ESC [ digit.
            ph_next = ESC_IDLE;
            if (key == CH_TILDE && held == CH_3 && cur < len) begin
              src_next   = cur + 1'b1;
              gap_next   = 7'd1;
              dcur_next  = cur;
              pv_next    = 1'b0;
              state_next = S_DOWN;
            end
          end else begin
            case (key)
              KEY_HOME:  cur_next = '0;
              KEY_CTLB:  if (cur != '0) cur_next = cur - 1'b1;
              KEY_END:   cur_next = len;
              KEY_RIGHT: if (cur < len) cur_next = cur + 1'b1;
              KEY_DEL: begin
                if (cur < len) begin
                  src_next   = cur + 1'b1;
                  gap_next   = 7'd1;
                  dcur_next  = cur;
                  pv_next    = 1'b0;
                  state_next = S_DOWN;
                end
              end
              KEY_BS, KEY_RUB: begin
                if (cur != '0) begin
                  src_next   = cur;
                  gap_next   = 7'd1;
                  dcur_next  = cur - 1'b1;
                  pv_next    = 1'b0;
                  state_next = S_DOWN;
                end
              end
              KEY_KILL: if (cur < len) len_next = cur;
              KEY_LF, KEY_CR, KEY_CTLO: begin
                // Finish: clear the editor, then stream the line out.
                en_next   = len;
                ei_next   = '0;
                cur_next  = '0;
                len_next  = '0;
                held_next = '0;
                if (len == '0) begin
                  kind_r_next = KIND_EMPTY;
                end else begin
                  state_next = S_EREQ;
                end
              end
              KEY_XPOSE: begin
                tmp = (cur != '0 && cur == len) ? cur - 1'b1 : cur;
                if (tmp != '0 && tmp < len) begin
                  tp_next    = tmp;
                  state_next = S_T0;
                end
              end
              KEY_KHOME: begin
                if (cur != '0) begin
                  src_next   = cur;
                  gap_next   = cur;
                  dcur_next  = '0;
                  pv_next    = 1'b0;
                  state_next = S_DOWN;
                end
              end
              KEY_WORD: begin
                wp_next    = cur;
                wph_next   = 1'b0;
                state_next = S_WREQ;
              end
              KEY_ESC: ph_next = ESC_FIRST;
              default: begin
                if (key >= CH_SPACE) begin
                  if (len >= LMAX) begin
                    full_r_next = 1'b1;
                  end else begin
                    cnt_next   = len - cur;
                    src_next   = len - 1'b1;
                    pv_next    = 1'b0;
                    state_next = S_UP;
                  end
                end
              end
            endcase
          end
        end
      end

      // Shift the tail down by gap entries, one entry a cycle.
      S_DOWN: begin
        we    = pv;
        waddr = pdst;
        raddr = src[AW-1:0];
        if (src < len) begin
          tmp       = src - gap;
          pdst_next = tmp[AW-1:0];
          pv_next   = 1'b1;
          src_next  = src + 1'b1;
        end else begin
          pv_next = 1'b0;
          if (!pv) begin
            len_next   = len - gap;
            cur_next   = dcur;
            state_next = S_RESP;
          end
        end
      end

      // Shift the tail up by one, starting from the end.
      S_UP: begin
        we    = pv;
        waddr = pdst;
        raddr = src[AW-1:0];
        if (cnt != '0) begin
          tmp       = src + 1'b1;
          pdst_next = tmp[AW-1:0];
          pv_next   = 1'b1;
          src_next  = src - 1'b1;
          cnt_next  = cnt - 1'b1;
        end else begin
          pv_next = 1'b0;
          if (!pv) state_next = S_INS;
        end
      end

      S_INS: begin
        we         = 1'b1;
        waddr      = cur[AW-1:0];
        wdata      = kreg;
        cur_next   = cur + 1'b1;
        len_next   = len + 1'b1;
        state_next = S_RESP;
      end

      // Transpose: read both characters, then write them swapped.
      S_T0: begin
        tmp        = tp - 1'b1;
        raddr      = tmp[AW-1:0];
        state_next = S_T1;
      end
      S_T1: begin
        ta_next    = rdata;
        raddr      = tp[AW-1:0];
        state_next = S_T2;
      end
      S_T2: begin
        tmp        = tp - 1'b1;
        we         = 1'b1;
        waddr      = tmp[AW-1:0];
        state_next = S_T3;
      end
      S_T3: begin
        we    = 1'b1;
        waddr = tp[AW-1:0];
        wdata = ta;
        if (cur < len) cur_next = cur + 1'b1;
        state_next = S_RESP;
      end

      // Word search: skip spaces, then the word, reading backward.
      S_WREQ: begin
        tmp   = wp - 1'b1;
        raddr = tmp[AW-1:0];
        if (wp == '0) begin
          src_next   = cur;
          gap_next   = cur - wp;
          dcur_next  = wp;
          pv_next    = 1'b0;
          state_next = S_DOWN;
        end else begin
          state_next = S_WCHK;
        end
      end
      S_WCHK: begin
        state_next = S_WREQ;
        if (rdata != CH_SPACE) begin
          wph_next = 1'b1;
          wp_next  = wp - 1'b1;
        end else if (!wph) begin
          wp_next = wp - 1'b1;
        end else begin
          src_next   = cur;
          gap_next   = cur - wp;
          dcur_next  = wp;
          pv_next    = 1'b0;
          state_next = S_DOWN;
        end
      end

      // Read the finished line out, one character per request.
      S_EREQ: begin
        raddr      = ei[AW-1:0];
        state_next = S_EDAT;
      end
      S_EDAT: begin
        raddr = ei[AW-1:0];
        if (slot_free) begin
          ovalid_next = 1'b1;
          okind_next  = KIND_CHAR;
          ochar_next  = rdata;
          ocur_next   = '0;
          olen_next   = '0;
          ofull_next  = 1'b0;
          tmp         = ei + 1'b1;
          olast_next  = (tmp == en);
          ei_next     = tmp;
          state_next  = (tmp == en) ? S_IDLE : S_EREQ;
        end
      end

      // Single status request for the key.
      S_RESP: begin
        if (slot_free) begin
          ovalid_next = 1'b1;
          okind_next  = kind_r;
          ochar_next  = '0;
          ocur_next   = cur;
          olen_next   = len;
          ofull_next  = full_r;
          olast_next  = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cur    <= '0;
      len    <= '0;
      ph     <= ESC_IDLE;
      held   <= '0;
      pv     <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      len    <= len_next;
      ph     <= ph_next;
      held   <= held_next;
      pv     <= pv_next;
      ovalid <= ovalid_next;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    kreg   <= kreg_next;
    ta     <= ta_next;
    kind_r <= kind_r_next;
    full_r <= full_r_next;
    wph    <= wph_next;
    src    <= src_next;
    gap    <= gap_next;
    dcur   <= dcur_next;
    cnt    <= cnt_next;
    tp     <= tp_next;
    wp     <= wp_next;
    ei     <= ei_next;
    en     <= en_next;
    pdst   <= pdst_next;
    okind  <= okind_next;
    ochar  <= ochar_next;
    ocur   <= ocur_next;
    olen   <= olen_next;
    ofull  <= ofull_next;
    olast  <= olast_next;
  end

  assign out_valid   = ovalid;
  assign kind        = okind;
  assign text_char   = ochar;
  assign cursor      = ocur;
  assign line_length = olen;
  assign full_res    = ofull;
  assign last        = olast;

endmodule

[src/tle_checker.sv]
// ----------------------------------------------------------------------------
// tle_checker: port-level checks for the line editor core
// Watches the result channel and checks consistency of its fields.
// ----------------------------------------------------------------------------
module tle_checker #(
  parameter int MAX_LEN = 64
) (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input tle_pkg::kind_t  kind,
  input tle_pkg::len_t   cursor,
  input tle_pkg::len_t   line_length,
  input logic            full_res,
  input logic            last
);
  import tle_pkg::*;

  // A stalled request keeps its valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  // Line and cancel requests report a cleared editor.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_STATUS |-> cursor == '0 && line_length == '0)
    else $error("cleared editor reports nonzero cursor or length");

  // The cursor never passes the end of the line, which never passes the store.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor <= line_length && line_length <= LEN_W'(MAX_LEN))
    else $error("cursor or length out of range");

  // A dropped insert only shows on a status request of a full line.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_res |-> kind == KIND_STATUS && line_length == LEN_W'(MAX_LEN))
    else $error("full flag on a line that is not full");

  // Only finished-line characters come as runs; everything else is single.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_CHAR |-> last)
    else $error("single request without last");

endmodule

bind terminal_line_editor_core tle_checker #(.MAX_LEN(MAX_LEN)) u_tle_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .cursor      (cursor),
  .line_length (line_length),
  .full_res    (full_res),
  .last        (last)
);

[verif/terminal_line_editor_core_tb.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor_core_tb: self-checking bench for the line editor
// Drives key requests in random bursts, mirrors the editor state in a local
// model and compares every result request field by field in order.
// ----------------------------------------------------------------------------
module terminal_line_editor_core_tb;
  import tle_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    kind_t kind;
    char_t ch;
    len_t  cur;
    len_t  len;
    logic  full;
    logic  last;
  } edit_result_t;

  // Keeps a copy of the editor and the queue of results it should produce.
  class editor_scoreboard;
    char_t          line [MAX_LEN];
    int             cur_pos;
    int             len;
    int             esc_phase;
    char_t          esc_held;
    edit_result_t   pending [$];
    int             errors;

    function void clear_line();
      cur_pos = 0;
      len = 0;
      esc_phase = 0;
      esc_held = '0;
    endfunction

    function void push(kind_t k, char_t c, logic f, logic l);
      edit_result_t r;
      r.kind = k;
      r.ch = c;
      r.cur = len_t'(cur_pos);
      r.len = len_t'(len);
      r.full = f;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void remove_span(int at, int cnt);
      if (cnt == 0 || at + cnt > len) return;
      for (int i = at; i + cnt < len; i++) line[i] = line[i + cnt];
      len -= cnt;
    endfunction

    function void delete_here();
      if (cur_pos < len) remove_span(cur_pos, 1);
    endfunction

    function void escape_byte(char_t k);
      int ph;
      ph = esc_phase;
      esc_phase = 0;
      if (ph == 1) begin
        esc_held = k;
        esc_phase = 2;
      end else if (ph == 2) begin
        if (esc_held == CH_O) begin
          if (k == CH_H) cur_pos = 0;
          else if (k == CH_F) cur_pos = len;
        end else if (esc_held == CH_BRACK) begin
          if (k >= CH_0 && k <= CH_9) begin
            esc_held = k;
            esc_phase = 3;
          end else if (k == CH_C) begin
            if (cur_pos < len) cur_pos++;
          end else if (k == CH_D) begin
            if (cur_pos > 0) cur_pos--;
          end else if (k == CH_H) cur_pos = 0;
          else if (k == CH_F) cur_pos = len;
        end
      end else if (ph == 3) begin
        if (k == CH_TILDE && esc_held == CH_3) delete_here();
      end
    endfunction

    // Notes one accepted key request and queues the results it causes.
    function void note_key(char_t k);
      logic  full;
      int    p;
      int    n;
      char_t t;
      char_t snap [MAX_LEN];
      full = 1'b0;
      if (k == KEY_NUL || (esc_phase == 0 && k == KEY_CTLC)) begin
        clear_line();
        push(KIND_CANCEL, '0, 1'b0, 1'b1);
        return;
      end
      if (esc_phase >= 1 && esc_phase <= 3) begin
        escape_byte(k);
        push(KIND_STATUS, '0, 1'b0, 1'b1);
        return;
      end
      esc_phase = 0;
      case (k)
        KEY_HOME: cur_pos = 0;
        KEY_CTLB: if (cur_pos > 0) cur_pos--;
        KEY_DEL: delete_here();
        KEY_END: cur_pos = len;
        KEY_RIGHT: if (cur_pos < len) cur_pos++;
        KEY_BS, KEY_RUB: begin
          if (len > 0 && cur_pos > 0) begin
            remove_span(cur_pos - 1, 1);
            cur_pos--;
          end
        end
        KEY_KILL: if (cur_pos < len) len = cur_pos;
        KEY_LF, KEY_CR, KEY_CTLO: begin
          n = len;
          snap = line;
          clear_line();
          if (n == 0) push(KIND_EMPTY, '0, 1'b0, 1'b1);
          for (int i = 0; i < n; i++) push(KIND_CHAR, snap[i], 1'b0, i + 1 == n);
          return;
        end
        KEY_XPOSE: begin
          p = cur_pos;
          if (p > 0 && p == len) p--;
          if (p > 0 && p < len) begin
            t = line[p - 1];
            line[p - 1] = line[p];
            line[p] = t;
            if (cur_pos < len) cur_pos++;
          end
        end
        KEY_KHOME: begin
          if (cur_pos > 0) begin
            remove_span(0, cur_pos);
            cur_pos = 0;
          end
        end
        KEY_WORD: begin
          p = cur_pos;
          while (p > 0 && line[p - 1] == CH_SPACE) p--;
          while (p > 0 && line[p - 1] != CH_SPACE) p--;
          remove_span(p, cur_pos - p);
          cur_pos = p;
        end
        KEY_ESC: esc_phase = 1;
        default: begin
          if (k >= CH_SPACE) begin
            if (len >= MAX_LEN) full = 1'b1;
            else begin
              for (int i = len; i > cur_pos; i--) line[i] = line[i - 1];
              line[cur_pos] = k;
              cur_pos++;
              len++;
            end
          end
        end
      endcase
      push(KIND_STATUS, '0, full, 1'b1);
    endfunction

    // Compares one accepted result request with the oldest expectation.
    function void check_result(edit_result_t got);
      edit_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind)
        $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
      if (got.ch !== exp_r.ch)
        $display("%0t: text_char expected %0d actual %0d", $time, exp_r.ch, got.ch);
      if (got.cur !== exp_r.cur)
        $display("%0t: cursor expected %0d actual %0d", $time, exp_r.cur, got.cur);
      if (got.len !== exp_r.len)
        $display("%0t: line_length expected %0d actual %0d", $time, exp_r.len, got.len);
      if (got.full !== exp_r.full)
        $display("%0t: full_res expected %0d actual %0d", $time, exp_r.full, got.full);
      if (got.last !== exp_r.last)
        $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  char_t key;
  logic  out_valid;
  logic  out_stall;
  kind_t kind;
  char_t text_char;
  len_t  cursor;
  len_t  line_length;
  logic  full_res;
  logic  last;

  editor_scoreboard board;
  int idle_cycles;
  int stall_mode;
  bit stim_done;

  terminal_line_editor_core #(.MAX_LEN(MAX_LEN)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .key(key),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .text_char(text_char), .cursor(cursor), .line_length(line_length),
    .full_res(full_res), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at each edge; results are checked as accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_key(key);
      if (out_valid && !out_stall)
        board.check_result({kind, text_char, cursor, line_length, full_res, last});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stall pattern: phases of no stall, light and heavy stalling.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Presents one key request and holds it until accepted.
  task automatic send_key(char_t k);
    in_valid <= 1'b1;
    key <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid for a random gap, sometimes none.
  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 3) != 0) return;
    gap = $urandom_range(1, 12);
    in_valid <= 1'b0;
    key <= char_t'($urandom);
    repeat (gap) @(posedge clk);
  endtask

  function automatic char_t printable();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return char_t'($urandom_range(128, 255));
      default: return char_t'($urandom_range(33, 126));
    endcase
  endfunction

  function automatic char_t random_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return printable();
    if (sel < 85) begin
      case ($urandom_range(0, 9))
        0: return KEY_HOME;
        1: return KEY_CTLB;
        2: return KEY_DEL;
        3: return KEY_END;
        4: return KEY_RIGHT;
        5: return KEY_BS;
        6: return KEY_XPOSE;
        7: return KEY_WORD;
        8: return KEY_RUB;
        default: return KEY_KILL;
      endcase
    end
    if (sel < 90) return char_t'($urandom_range(0, 31));
    if (sel < 93) return KEY_KHOME;
    if (sel < 97) return KEY_CR;
    return KEY_CTLC;
  endfunction

  // Sends an escape sequence, mostly well formed.
  task automatic send_escape();
    char_t fin [8];
    fin = '{CH_H, CH_F, CH_C, CH_D, 8'h41, 8'h42, CH_3, 8'h5A};
    send_key(KEY_ESC);
    case ($urandom_range(0, 4))
      0: begin
        send_key(CH_O);
        send_key($urandom_range(0, 1) ? CH_H : CH_F);
      end
      1, 2: begin
        send_key(CH_BRACK);
        send_key(fin[$urandom_range(0, 5)]);
      end
      3: begin
        send_key(CH_BRACK);
        send_key($urandom_range(0, 2) ? CH_3 : char_t'($urandom_range(48, 57)));
        send_key($urandom_range(0, 2) ? CH_TILDE : char_t'($urandom_range(1, 255)));
      end
      default: send_key(char_t'($urandom_range(1, 255)));
    endcase
  endtask

  initial begin
    automatic int sent = 0;
    char_t directed [$];
    board = new();
    board.clear_line();
    board.errors = 0;
    stim_done = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    key = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every edit key, escapes, cancel and finish cases.
    directed = '{KEY_CR, KEY_BS, KEY_CTLB, KEY_XPOSE, 8'h41, 8'hFF, CH_SPACE,
                 8'h7E, KEY_XPOSE, KEY_CTLB, KEY_CTLB, KEY_XPOSE, KEY_HOME,
                 KEY_DEL, KEY_END, KEY_RIGHT, KEY_WORD, 8'h09, KEY_RUB, 8'h80,
                 KEY_CTLB, KEY_KILL, KEY_KHOME, KEY_LF, KEY_CTLO};
    foreach (directed[i]) send_key(directed[i]);
    send_key(8'h42); send_key(KEY_ESC); send_key(KEY_NUL);
    send_key(KEY_ESC); send_key(KEY_CTLC); send_key(KEY_CTLC);

    // Fill the store past full, then finish the line; then cancel a new one.
    for (int i = 0; i < MAX_LEN + 2; i++) send_key(printable());
    send_key(KEY_CR);
    send_key(8'h55); send_key(KEY_NUL);

    // Random part: bursts with gaps, escapes mixed in.
    while (sent < 65) begin
      maybe_gap();
      if ($urandom_range(0, 9) == 0) send_escape();
      else send_key(random_key());
      sent++;
    end
    send_key(KEY_CR);
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run: drain expectations, then report.
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (board.pending.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0 && idle_cycles < WATCHDOG_LIMIT)
      $display("terminal_line_editor_core_tb passed");
    else
      $display("terminal_line_editor_core_tb failed");
    $finish;
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (!stim_done && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("terminal_line_editor_core_tb failed");
      $finish;
    end
  end
endmodule
